>>> design/olist_pkg.sv
package olist_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ECOUNT_W = 7;
  localparam int unsigned OUT_W    = 16;

  localparam logic [MODE_W-1:0] MODE_APPEND   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PREPEND  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CONTAINS = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD      = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_ACT,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } olist_state_t;

endpackage

>>> design/olist_ram.sv
module olist_ram
  import olist_pkg::*;
#(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(CAPACITY_DEF),
  parameter int unsigned DW    = VALUE_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

>>> design/ordered_list_engine_core.sv
// Clear and unused modes go straight to the result word; other modes scan the
// stored entries (count before the operation) one at a time, each read then
// compared, and a removal moves each later entry down, each read then written.
// A new word is taken only once the last is done; in_tready is high only while idle.
// Reset (rst_n low, synchronous) empties the list and drops out_tvalid;
// no clearing pass, memory contents are not cleared.
module ordered_list_engine_core
  import olist_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [VALUE_W-1:0] in_tdata,   // [31:0] value
  input  logic [MODE_W-1:0]  in_tuser,   // [2:0] mode
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata   // [1:0] status, [2] found, [9:3] entry_count, [15:10] zero
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [AW:0]   CAP_W  = (AW + 1)'(CAPACITY);
  localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

  olist_state_t state_r, state_nxt;

  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [VALUE_W-1:0]  value_r, value_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                found_r, found_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]    out_tdata_r, out_tdata_nxt;

  logic [CW-1:0]       map_off;
  logic [AW:0]         map_sum;
  logic [AW-1:0]       map_addr;
  logic [CW-1:0]       idx_inc;
  logic [CW+ECOUNT_W-1:0] cnt_ext;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [VALUE_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [VALUE_W-1:0]  ram_rdata;

  olist_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (VALUE_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (map_addr),
    .rdata_r (ram_rdata)
  );

  assign idx_inc = idx_r + CW'(1);

  // logical position -> memory address, ring starting at head
  always_comb begin
    unique case (state_r)
      ST_ACT:      map_off = count_r;
      ST_SHIFT_RD: map_off = idx_inc;
      default:     map_off = idx_r;
    endcase
    map_sum = {1'b0, head_r} + {1'b0, map_off[AW-1:0]};
    if (map_sum >= CAP_W) begin
      map_sum = map_sum - CAP_W;
    end
    map_addr = map_sum[AW-1:0];
  end

  assign cnt_ext = {{ECOUNT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    value_r     <= value_nxt;
    idx_r       <= idx_nxt;
    found_r     <= found_nxt;
    status_r    <= status_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    value_nxt      = value_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    status_nxt     = status_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    ram_we         = 1'b0;
    ram_waddr      = map_addr;
    ram_wdata      = value_r;
    ram_re         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt   = in_tuser;
          value_nxt  = in_tdata;
          idx_nxt    = '0;
          found_nxt  = 1'b0;
          status_nxt = STATUS_OK;
          if (in_tuser == MODE_CLEAR) begin
            count_nxt = '0;
            head_nxt  = '0;
            state_nxt = ST_DONE;
          end else if (in_tuser > MODE_CLEAR) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        if (idx_r == count_r) begin
          state_nxt = ST_ACT;
        end else begin
          ram_re    = 1'b1;
          state_nxt = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (ram_rdata == value_r) begin
          found_nxt = 1'b1;
          state_nxt = ST_ACT;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_ACT: begin
        state_nxt = ST_DONE;
        priority if (mode_r == MODE_APPEND || mode_r == MODE_PREPEND) begin
          if (count_r == CAP_C) begin
            status_nxt = STATUS_FULL;
          end else if (mode_r == MODE_APPEND) begin
            ram_we    = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            head_nxt  = (head_r == '0) ? LAST_A : head_r - AW'(1);
            ram_we    = 1'b1;
            ram_waddr = head_nxt;
            count_nxt = count_r + CW'(1);
          end
        end else if (!found_r) begin
          status_nxt = STATUS_NOTFOUND;
        end else if (mode_r == MODE_REMOVE) begin
          state_nxt = ST_SHIFT_RD;
        end else begin
          status_nxt = STATUS_OK;
        end
      end
      ST_SHIFT_RD: begin
        if (idx_inc == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          state_nxt = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        idx_nxt   = idx_inc;
        state_nxt = ST_SHIFT_RD;
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{(OUT_W - ECOUNT_W - 1 - STATUS_W){1'b0}},
                            cnt_ext[ECOUNT_W-1:0], found_r, status_r};
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

>>> design/olist_chk.sv
module olist_chk
  import olist_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [OUT_W-1:0]   out_tdata
);

  localparam logic [ECOUNT_W-1:0] CAP_E = ECOUNT_W'(CAPACITY);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a word is still in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != STATUS_BAD)
    else $error("undefined status code");

  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1:0] != STATUS_NOTFOUND)
    else $error("found word reported as not found");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (CAPACITY < 128) |-> out_tdata[9:3] <= CAP_E)
    else $error("entry count above capacity");

endmodule

bind ordered_list_engine_core olist_chk #(.CAPACITY(CAPACITY)) u_olist_chk (.*);
